@@ sv/wlmf_pkg.sv @@
// Shared constants, types and result codes for the windowed local minimum finder.
package wlmf_pkg;

	localparam int HALF_WINDOW   = 5;
	localparam int WIN_LEN       = 2 * HALF_WINDOW + 1;
	localparam int VALUE_BITS    = 32;
	localparam int INDEX_BITS    = 12;
	localparam int MAX_LENGTH    = 4096;
	localparam int COUNT_BITS    = $clog2(MAX_LENGTH) + 1;
	localparam int LPOS_BITS     = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
	localparam int MAX_RESULTS   = 3;
	localparam int SLOT_BITS     = $clog2(MAX_RESULTS + 1);
	localparam int FIFO_DEPTH    = 8;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
	localparam int IN_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8;

	typedef logic [VALUE_BITS-1:0]               value_t;
	typedef logic [WIN_LEN-1:0][VALUE_BITS-1:0]  window_t;
	typedef logic [COUNT_BITS-1:0]               count_t;
	typedef logic [INDEX_BITS-1:0]               index_t;

	typedef enum logic [1:0] {
		KIND_INTERIOR = 2'd0,
		KIND_LEFT     = 2'd1,
		KIND_RIGHT    = 2'd2,
		KIND_FALLBACK = 2'd3
	} kind_t;

	typedef struct packed {
		logic   last;
		kind_t  kind;
		index_t index;
	} result_t;

	typedef result_t [MAX_RESULTS-1:0] result_group_t;

	// End-of-sequence findings over the right-hand group of the window
	typedef struct packed {
		logic   long_enough;
		logic   right_found;
		index_t right_index;
		index_t fall_index;
	} tail_t;

endpackage

@@ sv/wlmf_cell.sv @@
// One window cell: holds a sample, passes it on, flags whether it lies above the center.
module wlmf_cell
	import wlmf_pkg::*;
(
	input  logic   clk,
	input  logic   shift,
	input  value_t din,
	input  value_t center,
	output value_t q,
	output logic   above
);

	value_t value_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			value_q <= din;
		end
	end

	assign q     = value_q;
	assign above = value_q > center;

endmodule

@@ sv/wlmf_tail.sv @@
// End-of-sequence search: right-edge minimum and fallback position from the window.
module wlmf_tail
	import wlmf_pkg::*;
(
	input  window_t                win,
	input  count_t                 count,
	input  value_t                 lmin_value,
	input  logic [LPOS_BITS-1:0]   lmin_index,
	output tail_t                  tail
);

	logic [WIN_LEN-1:0] first_min;
	logic               right_any;
	logic               fall_any;
	count_t             right_pos;

	// Mark the first position holding the lowest value of the right group
	always_comb begin
		first_min = '0;
		for (int k = HALF_WINDOW + 1; k < WIN_LEN; k++) begin
			first_min[k] = 1'b1;
			for (int j = HALF_WINDOW + 1; j < WIN_LEN; j++) begin
				if (j < k && !(win[k] < win[j])) begin
					first_min[k] = 1'b0;
				end
				if (j > k && (win[j] < win[k])) begin
					first_min[k] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		right_any = 1'b0;
		fall_any  = 1'b0;
		right_pos = '0;
		for (int k = HALF_WINDOW + 1; k < WIN_LEN; k++) begin
			right_any = right_any | (win[k] < win[HALF_WINDOW]);
			fall_any  = fall_any | (win[k] < lmin_value);
			if (first_min[k]) begin
				right_pos = right_pos | (count - COUNT_BITS'(WIN_LEN - k));
			end
		end
	end

	always_comb begin
		tail.long_enough = count >= COUNT_BITS'(WIN_LEN);
		tail.right_found = right_any;
		tail.right_index = right_pos[INDEX_BITS-1:0];
		if (tail.long_enough && fall_any) begin
			tail.fall_index = right_pos[INDEX_BITS-1:0];
		end else begin
			tail.fall_index = INDEX_BITS'(lmin_index);
		end
	end

endmodule

@@ sv/wlmf_fifo.sv @@
// Result queue: takes up to three results a cycle, hands out one.
module wlmf_fifo
	import wlmf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SLOT_BITS-1:0] push_cnt,
	input  result_group_t        push_data,
	input  logic                 pop,
	output result_t              head,
	output logic [FIFO_AW:0]     level
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     level_q;

	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_RESULTS; j++) begin
			if (SLOT_BITS'(j) < push_cnt) begin
				mem_q[wr_ptr_q + FIFO_AW'(j)] <= push_data[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			level_q  <= level_q + (FIFO_AW + 1)'(push_cnt) - (FIFO_AW + 1)'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign level = level_q;

endmodule

@@ sv/windowed_local_minimum_finder.sv @@
// Top level: sliding-window local minimum finder over a stream of cost samples.
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------------
//  s_axis    | in        | tdata[31:0] sample_value, tlast last_sample
//  m_axis    | out       | tdata[11:0] minimum_index, tuser minimum_kind, tlast end_of_list
//
// Cycles: one sample per cycle while s_axis_tready is high. A sample enters the window at its
// request; in the next cycle its window is evaluated and up to three results go into an
// eight-entry queue, which drains one result per cycle while m_axis_tready is high.
// Reset: arst_n clears all control state; window cells hold no reset value.
// Stalls: s_axis_tready drops only when the queue might not take the next sample's results;
// a waiting result on m_axis does not by itself stop input.
module windowed_local_minimum_finder
	import wlmf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // [31:0] sample_value
	input  logic                     s_axis_tlast,   // last_sample
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // [11:0] minimum_index, rest zero
	output logic [1:0]               m_axis_tuser,   // [1:0] minimum_kind
	output logic                     m_axis_tlast    // end_of_list
);

	// ---------------------------------------------------------------- input side
	logic   accept;
	value_t sample;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign sample = s_axis_tdata[VALUE_BITS-1:0];

	// Row of cells; the newest sample enters at the top end
	window_t            win;
	logic [WIN_LEN-1:0] above;

	for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
		value_t din;
		if (k == WIN_LEN - 1) begin : g_head
			assign din = sample;
		end else begin : g_body
			assign din = win[k+1];
		end
		wlmf_cell u_cell (
			.clk    (clk),
			.shift  (accept),
			.din    (din),
			.center (win[HALF_WINDOW]),
			.q      (win[k]),
			.above  (above[k])
		);
	end

	// Per-sequence bookkeeping, updated at each input request
	count_t                 count_q;
	value_t                 lmin_val_q;
	logic [LPOS_BITS-1:0]   lmin_idx_q;
	logic                   left_found_q;
	logic [LPOS_BITS-1:0]   left_idx_q;
	logic                   fresh_q;      // previous request closed a sequence

	count_t                 pos;
	value_t                 lmin_base;
	logic [LPOS_BITS-1:0]   lidx_base;
	count_t                 count_d;
	value_t                 lmin_val_d;
	logic [LPOS_BITS-1:0]   lmin_idx_d;
	logic                   left_found_d;
	logic [LPOS_BITS-1:0]   left_idx_d;

	// After the last sample the old state stays for evaluation; the next request
	// starts from reset values instead.
	always_comb begin
		pos          = fresh_q ? '0 : count_q;
		lmin_base    = fresh_q ? '1 : lmin_val_q;
		lidx_base    = fresh_q ? '0 : lmin_idx_q;
		left_found_d = fresh_q ? 1'b0 : left_found_q;
		left_idx_d   = fresh_q ? '0 : left_idx_q;
		lmin_val_d   = lmin_base;
		lmin_idx_d   = lidx_base;
		count_d      = (pos < COUNT_BITS'(MAX_LENGTH)) ? pos + COUNT_BITS'(1) : pos;
		if (pos < COUNT_BITS'(HALF_WINDOW)) begin
			if (sample < lmin_base) begin
				lmin_val_d = sample;
				lmin_idx_d = pos[LPOS_BITS-1:0];
			end
		end else if (pos == COUNT_BITS'(HALF_WINDOW)) begin
			left_found_d = lmin_base < sample;
			left_idx_d   = lidx_base;
		end
	end

	logic valid_s1;
	logic last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			lmin_val_q   <= '1;
			lmin_idx_q   <= '0;
			left_found_q <= 1'b0;
			left_idx_q   <= '0;
			fresh_q      <= 1'b0;
			valid_s1     <= 1'b0;
			last_s1      <= 1'b0;
		end else begin
			valid_s1 <= accept;
			last_s1  <= accept && s_axis_tlast;
			if (accept) begin
				count_q      <= count_d;
				lmin_val_q   <= lmin_val_d;
				lmin_idx_q   <= lmin_idx_d;
				left_found_q <= left_found_d;
				left_idx_q   <= left_idx_d;
				fresh_q      <= s_axis_tlast;
			end
		end
	end

	// ---------------------------------------------------------------- evaluation
	tail_t tail;

	wlmf_tail u_tail (
		.win        (win),
		.count      (count_q),
		.lmin_value (lmin_val_q),
		.lmin_index (lmin_idx_q),
		.tail       (tail)
	);

	// Interior test: center strictly below every other cell of a full window
	logic is_min;

	always_comb begin
		is_min = tail.long_enough;
		for (int k = 0; k < WIN_LEN; k++) begin
			if (k != HALF_WINDOW && !above[k]) begin
				is_min = 1'b0;
			end
		end
	end

	// Newest interior minimum is held back so end_of_list can land on it
	logic   pending_q;
	index_t pending_idx_q;
	logic   any_q;
	count_t new_pos;
	index_t new_idx;
	logic   pend_v_next;
	index_t pend_idx_next;

	assign new_pos       = count_q - COUNT_BITS'(HALF_WINDOW + 1);
	assign new_idx       = new_pos[INDEX_BITS-1:0];
	assign pend_v_next   = is_min || pending_q;
	assign pend_idx_next = is_min ? new_idx : pending_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q     <= 1'b0;
			pending_idx_q <= '0;
			any_q         <= 1'b0;
		end else if (valid_s1) begin
			if (last_s1) begin
				pending_q     <= 1'b0;
				pending_idx_q <= '0;
				any_q         <= 1'b0;
			end else if (is_min) begin
				pending_q     <= 1'b1;
				pending_idx_q <= new_idx;
				any_q         <= 1'b1;
			end
		end
	end

	// Candidate results in emission order: released interior, held interior,
	// left edge, right edge, fallback
	localparam int NCAND = 5;

	result_t              cand   [NCAND];
	logic [NCAND-1:0]     cand_v;
	result_group_t        grp;
	logic [SLOT_BITS-1:0] n_res;
	logic                 right_hit;

	assign right_hit = tail.long_enough && tail.right_found;

	always_comb begin
		cand[0] = '{last: 1'b0, kind: KIND_INTERIOR, index: pending_idx_q};
		cand[1] = '{last: 1'b0, kind: KIND_INTERIOR, index: pend_idx_next};
		cand[2] = '{last: 1'b0, kind: KIND_LEFT, index: INDEX_BITS'(left_idx_q)};
		cand[3] = '{last: 1'b0, kind: KIND_RIGHT, index: tail.right_index};
		cand[4] = '{last: 1'b0, kind: KIND_FALLBACK, index: tail.fall_index};
		cand_v[0] = valid_s1 && is_min && pending_q;
		cand_v[1] = valid_s1 && last_s1 && pend_v_next;
		cand_v[2] = valid_s1 && last_s1 && left_found_q;
		cand_v[3] = valid_s1 && last_s1 && right_hit;
		cand_v[4] = valid_s1 && last_s1 && !(is_min || any_q) && !left_found_q && !right_hit;
	end

	// Pack valid candidates into consecutive slots; mark the final one of a sequence
	always_comb begin
		grp   = '0;
		n_res = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cand_v[i] && n_res < SLOT_BITS'(MAX_RESULTS)) begin
				grp[n_res] = cand[i];
				n_res      = n_res + SLOT_BITS'(1);
			end
		end
		if (last_s1 && n_res != '0) begin
			grp[n_res - SLOT_BITS'(1)].last = 1'b1;
		end
	end

	// ---------------------------------------------------------------- output side
	result_t          head;
	logic [FIFO_AW:0] level;
	logic             pop;

	assign pop = m_axis_tvalid && m_axis_tready;

	wlmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (n_res),
		.push_data (grp),
		.pop       (pop),
		.head      (head),
		.level     (level)
	);

	// Hold input while the queue could not absorb both the sample under evaluation
	// and the next one at their worst case
	logic [FIFO_AW+1:0] reserve;

	assign reserve       = (FIFO_AW + 2)'(level) + (valid_s1 ? (FIFO_AW + 2)'(MAX_RESULTS) : '0);
	assign s_axis_tready = reserve <= (FIFO_AW + 2)'(FIFO_DEPTH - MAX_RESULTS);

	assign m_axis_tvalid = level != '0;
	assign m_axis_tdata  = OUT_DATA_BITS'(head.index);
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

endmodule
